FILE: rtl/alias_table_sampler_assert.svh
// assertion macros for the alias table sampler checker
// no dependencies
`ifndef ALIAS_TABLE_SAMPLER_ASSERT_SVH
`define ALIAS_TABLE_SAMPLER_ASSERT_SVH
`define ATS_ASSERT_IMPL(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define ATS_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

FILE: rtl/ats_pkg.sv
// package for the alias table sampler: widths, codes, state enum
// no dependencies
package ats_pkg;
	localparam int DEPTH_DEF = 1024;
	localparam int RANDOM_BITS_DEF = 32;
	localparam int CMD_W = 2;
	localparam int WEIGHT_W = 32;
	localparam int RAND_W = 32;
	localparam int ID_W = 10;
	localparam int STATUS_W = 2;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_BUILD = 2'd1,
		CMD_SAMPLE = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_EMPTY = 2'd2,
		ST_ZERO = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SAMP,
		S_PART_RD,
		S_PART_WR,
		S_PAIR_RD,
		S_PAIR_DIV,
		S_PAIR_WR,
		S_FILL_RD,
		S_FILL_WR,
		S_DONE
	} state_t;
endpackage

FILE: rtl/ats_if.sv
// valid/ready channel interfaces for the alias table sampler
// depends on ats_pkg
interface ats_in_if import ats_pkg::*; ();
	logic valid;
	logic ready;
	logic [CMD_W-1:0] command;
	logic [WEIGHT_W-1:0] weight;
	logic [RAND_W-1:0] random_value;
	modport source(output valid, command, weight, random_value, input ready);
	modport sink(input valid, command, weight, random_value, output ready);
endinterface

interface ats_out_if import ats_pkg::*; ();
	logic valid;
	logic ready;
	logic [ID_W-1:0] outcome_id;
	logic [STATUS_W-1:0] status;
	modport source(output valid, outcome_id, status, input ready);
	modport sink(input valid, outcome_id, status, output ready);
endinterface

FILE: rtl/ats_div.sv
// bit-serial divider for keep levels: ceil(s * 2^RB / sum), one bit a cycle
// depends on ats_pkg
module ats_div import ats_pkg::*; #(
	parameter int RB = RANDOM_BITS_DEF,
	parameter int SW = 53
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [SW-1:0] num,
	input  logic [SW-1:0] den,
	output logic done,
	output logic [RB:0] level
);
	localparam int CW = $clog2(RB + 1);
	logic [SW:0] r_q;
	logic [RB:0] q_q;
	logic [CW-1:0] k_q;
	logic busy_q;
	logic [SW:0] r2;
	logic [RB:0] one;
	logic sat;

	assign r2 = {r_q[SW-1:0], 1'b0};
	assign one = {1'b1, {RB{1'b0}}};
	assign sat = (RB >= 64);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			k_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q <= '0;
			end else if (busy_q) begin
				k_q <= k_q + CW'(1);
				if (k_q == CW'(RB - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= {1'b0, num};
			q_q <= '0;
		end else if (busy_q) begin
			if (r2 >= {1'b0, den}) begin
				r_q <= r2 - {1'b0, den};
				q_q <= {q_q[RB-1:0], 1'b1};
			end else begin
				r_q <= r2;
				q_q <= {q_q[RB-1:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (r_q != '0) begin
			if (sat && q_q[RB-1:0] == {RB{1'b1}})
				level = q_q;
			else
				level = q_q + (RB+1)'(1);
		end else begin
			level = q_q;
		end
		if (level > one)
			level = one;
	end
endmodule

FILE: rtl/ats_core.sv
// control and table memories of the alias table sampler
// depends on ats_pkg, ats_if, ats_div
module ats_core import ats_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ats_in_if.sink in_ch,
	ats_out_if.source out_ch
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;
	localparam int SUMW = WEIGHT_W + CW;
	localparam int SCW = WEIGHT_W + CW;
	localparam int LW = RANDOM_BITS + 1;
	localparam int PW = RANDOM_BITS + CW;
	localparam logic [LW-1:0] LEVEL_ONE = {1'b1, {RANDOM_BITS{1'b0}}};

	logic [WEIGHT_W-1:0] wmem [DEPTH];
	logic [AW-1:0] own_mem [DEPTH];
	logic [AW-1:0] alias_mem [DEPTH];
	logic [LW-1:0] level_mem [DEPTH];
	logic [SCW-1:0] sc_mem [DEPTH];

	state_t st_q, st_d;
	logic [SUMW-1:0] sum_q;
	logic [CW-1:0] cnt_q;
	logic ready_q;
	logic [CW-1:0] i_q, lo_q, l_q, s_q;
	logic ov_q;
	logic [ID_W-1:0] oid_q;
	logic [STATUS_W-1:0] ost_q;

	logic [WEIGHT_W-1:0] wrd_s1;
	logic [AW-1:0] own_s1, alias_s1;
	logic [LW-1:0] lvl_s1;
	logic [SCW-1:0] scs_s1, scl_s1;
	logic [AW-1:0] ownl_s1;
	logic [RANDOM_BITS-1:0] frac_s1;
	logic [SCW-1:0] scs_q, scl_q;
	logic [AW-1:0] ownl_q;

	logic acc, div_start, div_done;
	logic [LW-1:0] div_level;
	logic [PW-1:0] prod;
	logic [RANDOM_BITS-1:0] rnd;
	logic [CW-1:0] idx;
	logic [SCW:0] sc_cur;
	logic [SCW+1:0] newl;

	assign in_ch.ready = (st_q == S_IDLE) && !ov_q;
	assign acc = in_ch.valid && in_ch.ready;
	assign out_ch.valid = ov_q;
	assign out_ch.outcome_id = oid_q;
	assign out_ch.status = ost_q;

	assign rnd = RANDOM_BITS'(in_ch.random_value);
	assign prod = PW'(rnd) * PW'(cnt_q);
	always_comb begin
		idx = CW'(prod >> RANDOM_BITS);
		if (idx >= cnt_q)
			idx = cnt_q - CW'(1);
	end
	assign sc_cur = (SCW+1)'(wrd_s1) * (SCW+1)'(cnt_q);
	assign newl = (SCW+2)'(scl_q) + (SCW+2)'(scs_q) - (SCW+2)'(sum_q);

	ats_div #(.RB(RANDOM_BITS), .SW(SCW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(scs_q), .den(SCW'(sum_q)), .done(div_done), .level(div_level)
	);

	// memory reads, registered
	always_ff @(posedge clk) begin
		wrd_s1 <= wmem[i_q[AW-1:0]];
		if (acc)
			frac_s1 <= prod[RANDOM_BITS-1:0];
		own_s1 <= own_mem[(acc ? idx[AW-1:0] : s_q[AW-1:0])];
		alias_s1 <= alias_mem[idx[AW-1:0]];
		lvl_s1 <= level_mem[idx[AW-1:0]];
		scs_s1 <= sc_mem[s_q[AW-1:0]];
		scl_s1 <= sc_mem[l_q[AW-1:0]];
		ownl_s1 <= own_mem[l_q[AW-1:0]];
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE: begin
				if (acc && in_ch.command == CMD_SAMPLE && ready_q && cnt_q != '0)
					st_d = S_SAMP;
				else if (acc && in_ch.command == CMD_BUILD && cnt_q != '0 && sum_q != '0)
					st_d = S_PART_RD;
			end
			S_SAMP: st_d = S_IDLE;
			S_PART_RD: st_d = S_PART_WR;
			S_PART_WR: st_d = (i_q + CW'(1) == cnt_q) ? S_PAIR_RD : S_PART_RD;
			S_PAIR_RD: begin
				if (s_q == l_q || l_q == cnt_q)
					st_d = S_FILL_RD;
				else
					st_d = S_PAIR_DIV;
			end
			S_PAIR_DIV: begin
				if (div_done)
					st_d = S_PAIR_WR;
			end
			S_PAIR_WR: st_d = S_PAIR_RD;
			S_FILL_RD: st_d = (s_q >= cnt_q) ? S_DONE : S_FILL_WR;
			S_FILL_WR: st_d = S_FILL_RD;
			S_DONE: st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	logic pair_go_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pair_go_q <= 1'b0;
		else pair_go_q <= (st_q == S_PAIR_RD) && !(s_q == l_q || l_q == cnt_q);
	end

	always_ff @(posedge clk) begin
		if (pair_go_q) begin
			scs_q <= scs_s1;
			scl_q <= scl_s1;
			ownl_q <= ownl_s1;
		end
	end

	logic div_go;
	assign div_go = pair_go_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			sum_q <= '0;
			cnt_q <= '0;
			ready_q <= 1'b0;
			ov_q <= 1'b0;
			i_q <= '0;
			lo_q <= '0;
			l_q <= '0;
			s_q <= '0;
			oid_q <= '0;
			ost_q <= ST_OK;
		end else begin
			st_q <= st_d;
			if (out_ch.valid && out_ch.ready)
				ov_q <= 1'b0;
			if (acc) begin
				oid_q <= '0;
				ost_q <= ST_OK;
				unique case (in_ch.command)
					CMD_LOAD: begin
						ov_q <= 1'b1;
						if (cnt_q >= CW'(DEPTH)) begin
							ost_q <= ST_FULL;
						end else begin
							sum_q <= sum_q + SUMW'(in_ch.weight);
							cnt_q <= cnt_q + CW'(1);
							ready_q <= 1'b0;
						end
					end
					CMD_BUILD: begin
						ready_q <= 1'b0;
						i_q <= '0;
						lo_q <= '0;
						l_q <= cnt_q;
						s_q <= '0;
						if (cnt_q == '0) begin
							ost_q <= ST_EMPTY;
							ov_q <= 1'b1;
						end else if (sum_q == '0) begin
							ost_q <= ST_ZERO;
							ov_q <= 1'b1;
						end
					end
					CMD_SAMPLE: begin
						if (!ready_q || cnt_q == '0) begin
							ost_q <= ST_EMPTY;
							ov_q <= 1'b1;
						end
					end
					CMD_CLEAR: begin
						cnt_q <= '0;
						sum_q <= '0;
						ready_q <= 1'b0;
						ov_q <= 1'b1;
					end
					default: ;
				endcase
			end
			unique case (st_q)
				S_SAMP: begin
					oid_q <= ID_W'(((frac_s1 < lvl_s1[RANDOM_BITS-1:0]) || lvl_s1[RANDOM_BITS])
						? own_s1 : alias_s1);
					ov_q <= 1'b1;
				end
				S_PART_WR: begin
					i_q <= i_q + CW'(1);
					if (sc_cur <= (SCW+1)'(sum_q)) lo_q <= lo_q + CW'(1);
					else l_q <= l_q - CW'(1);
				end
				S_PART_RD: begin
					if (i_q == '0) l_q <= cnt_q;
				end
				S_PAIR_WR: begin
					if (newl <= (SCW+2)'(sum_q)) l_q <= l_q + CW'(1);
					s_q <= s_q + CW'(1);
				end
				S_FILL_WR: s_q <= s_q + CW'(1);
				S_DONE: begin
					ready_q <= 1'b1;
					ov_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (acc && in_ch.command == CMD_LOAD && cnt_q < CW'(DEPTH))
			wmem[cnt_q[AW-1:0]] <= in_ch.weight;
		if (st_q == S_PART_WR) begin
			if (sc_cur <= (SCW+1)'(sum_q)) begin
				own_mem[lo_q[AW-1:0]] <= i_q[AW-1:0];
				alias_mem[lo_q[AW-1:0]] <= i_q[AW-1:0];
				sc_mem[lo_q[AW-1:0]] <= SCW'(sc_cur);
			end else begin
				own_mem[l_q[AW-1:0] - AW'(1)] <= i_q[AW-1:0];
				alias_mem[l_q[AW-1:0] - AW'(1)] <= i_q[AW-1:0];
				sc_mem[l_q[AW-1:0] - AW'(1)] <= SCW'(sc_cur);
			end
		end
		if (st_q == S_PAIR_WR) begin
			alias_mem[s_q[AW-1:0]] <= ownl_q;
			level_mem[s_q[AW-1:0]] <= div_level;
			sc_mem[l_q[AW-1:0]] <= SCW'(newl);
		end
		if (st_q == S_FILL_WR) begin
			alias_mem[s_q[AW-1:0]] <= own_s1;
			level_mem[s_q[AW-1:0]] <= LEVEL_ONE;
		end
	end

	logic div_seen_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_seen_q <= 1'b0;
		else div_seen_q <= div_go;
	end
	// kick the divider once the operands are latched
	assign div_start = div_seen_q;
endmodule

FILE: rtl/alias_table_sampler.sv
// alias table sampler: load, build, sample, clear over a valid/ready request and a valid/ready answer channel
// answers: load, clear and errors answer the cycle after acceptance; a sample answers from registered reads in S_SAMP
// flow: one item at a time; no new request is taken while an answer is pending or a build runs
// build: partition, then pairing with a divider run per pair, then fill of leftover slots, then done
// reset: arst_n clears count, sum, ready flag and control; memories need no reset
module alias_table_sampler import ats_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ats_in_if.sink in_ch,
	ats_out_if.source out_ch
);
	ats_core #(.DEPTH(DEPTH), .RANDOM_BITS(RANDOM_BITS)) u_core (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch)
	);
endmodule

FILE: rtl/ats_checker.sv
// port-level checker for the alias table sampler, bound to the top level
// depends on ats_pkg and alias_table_sampler_assert.svh
`include "alias_table_sampler_assert.svh"
module ats_checker import ats_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [ID_W-1:0] outcome_id,
	input logic [STATUS_W-1:0] status
);
	`ATS_ASSERT_IMPL(a_busy_no_take, out_valid && !out_ready, !in_ready)
	`ATS_ASSERT_IMPL(a_err_zero_id, out_valid && status != ST_OK, outcome_id == '0)
	`ATS_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(status))
endmodule

bind alias_table_sampler ats_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.outcome_id(out_ch.outcome_id), .status(out_ch.status)
);

FILE: tb/alias_table_sampler_test.sv
// testbench for alias_table_sampler: directed and random load/build/sample/clear traffic
// with bursty sending and stalled receiving, checked against an in-bench alias table model
// depends on ats_pkg, ats_in_if, ats_out_if and the alias_table_sampler rtl
module alias_table_sampler_test;
	import ats_pkg::*;

	localparam int N_MAX = DEPTH_DEF;
	localparam longint unsigned LEVEL_ONE = 64'd1 << RANDOM_BITS_DEF;
	localparam longint unsigned FRAC_MASK = LEVEL_ONE - 1;

	typedef struct {
		cmd_t cmd;
		logic [WEIGHT_W-1:0] weight;
		logic [RAND_W-1:0] rnd;
		bit drain;
	} request_t;

	typedef struct {
		logic [ID_W-1:0] id;
		status_t status;
	} answer_t;

	logic clk;
	logic arst_n;
	ats_in_if in_ch();
	ats_out_if out_ch();

	alias_table_sampler dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	request_t pending_requests[$];
	answer_t expected_answers[$];
	int mismatches;
	int burst_left;
	int gap_left;
	int stall_mode;
	int stall_left;

	// model state
	logic [31:0] weights[N_MAX];
	longint unsigned total_weight;
	int loaded;
	bit built;
	int slot_own[N_MAX];
	int slot_alias[N_MAX];
	longint unsigned slot_level[N_MAX];
	longint unsigned work[N_MAX];

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic longint unsigned keep_threshold(longint unsigned s, longint unsigned sum);
		logic [95:0] num;
		if (s >= sum)
			return LEVEL_ONE;
		num = {32'd0, s} << RANDOM_BITS_DEF;
		return 64'((num + sum - 1) / sum);
	endfunction

	function automatic void build_alias_table();
		longint unsigned n, sc;
		int lo, hi, s, i, slot;
		n = loaded;
		lo = 0;
		hi = loaded;
		for (i = 0; i < loaded; i++) begin
			sc = longint'(weights[i]) * n;
			if (sc <= total_weight) begin
				slot = lo;
				lo++;
			end else begin
				hi--;
				slot = hi;
			end
			slot_own[slot] = i;
			slot_alias[slot] = i;
			work[slot] = sc;
		end
		s = 0;
		while (s != hi && hi != loaded) begin
			slot_alias[s] = slot_own[hi];
			slot_level[s] = keep_threshold(work[s], total_weight);
			work[hi] = work[hi] + work[s] - total_weight;
			if (work[hi] <= total_weight)
				hi++;
			s++;
		end
		for (; s < loaded; s++) begin
			slot_alias[s] = slot_own[s];
			slot_level[s] = LEVEL_ONE;
		end
	endfunction

	function automatic answer_t sample_outcome(request_t r);
		answer_t a;
		longint unsigned prod, idx, frac;
		a.id = '0;
		a.status = ST_OK;
		case (r.cmd)
			CMD_LOAD: begin
				if (loaded >= N_MAX)
					a.status = ST_FULL;
				else begin
					weights[loaded] = r.weight;
					total_weight += r.weight;
					loaded++;
					built = 0;
				end
			end
			CMD_BUILD: begin
				built = 0;
				if (loaded == 0)
					a.status = ST_EMPTY;
				else if (total_weight == 0)
					a.status = ST_ZERO;
				else begin
					build_alias_table();
					built = 1;
				end
			end
			CMD_SAMPLE: begin
				if (!built || loaded == 0)
					a.status = ST_EMPTY;
				else begin
					prod = longint'(r.rnd) * longint'(loaded);
					idx = prod >> RANDOM_BITS_DEF;
					frac = prod & FRAC_MASK;
					if (idx >= loaded)
						idx = loaded - 1;
					a.id = ID_W'((frac < slot_level[idx]) ? slot_own[idx] : slot_alias[idx]);
				end
			end
			default: begin
				loaded = 0;
				total_weight = 0;
				built = 0;
			end
		endcase
		return a;
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'hffff_ffff;
			2, 3: return $urandom_range(1, 100);
			4: return $urandom >> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_request(cmd_t cmd, logic [31:0] w = 0, logic [31:0] rv = 0,
			bit drain = 0);
		request_t r;
		r.cmd = cmd;
		r.weight = w;
		r.rnd = rv;
		r.drain = drain;
		pending_requests.push_back(r);
	endtask

	// driver: bursts and gaps, predicts each transfer as it is accepted
	always @(posedge clk or negedge arst_n) begin
		request_t r;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.command <= CMD_LOAD;
			in_ch.weight <= '0;
			in_ch.random_value <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				r.cmd = cmd_t'(in_ch.command);
				r.weight = in_ch.weight;
				r.rnd = in_ch.random_value;
				expected_answers.push_back(sample_outcome(r));
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_ch.valid <= 1'b0;
				end else if (pending_requests.size() > 0 &&
						!(pending_requests[0].drain &&
						(expected_answers.size() > 0 || in_ch.valid))) begin
					r = pending_requests.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.command <= r.cmd;
					in_ch.weight <= r.weight;
					in_ch.random_value <= r.rnd;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else
						burst_left <= burst_left - 1;
				end else
					in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_mode <= 0;
			stall_left <= 0;
		end else begin
			if (stall_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				stall_left <= $urandom_range(20, 200);
			end else
				stall_left <= stall_left - 1;
			case (stall_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= $urandom_range(0, 1);
				2: out_ch.ready <= ($urandom_range(0, 7) == 0);
				default: out_ch.ready <= (stall_left % 5) < 2;
			endcase
		end
	end

	// monitor
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: id %0d status %0d",
						out_ch.outcome_id, out_ch.status);
			end else begin
				e = expected_answers.pop_front();
				if (out_ch.outcome_id !== e.id || out_ch.status !== e.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected id %0d status %0d, got id %0d status %0d",
							e.id, e.status, out_ch.outcome_id, out_ch.status);
				end
			end
		end
	end

	initial begin
		int count, k, i, kind;
		bit full_done;
		mismatches = 0;
		total_weight = 0;
		loaded = 0;
		built = 0;
		full_done = 0;
		arst_n = 1'b0;

		// directed
		queue_request(CMD_SAMPLE, 0, 32'h1234);
		queue_request(CMD_BUILD);
		queue_request(CMD_LOAD, 0);
		queue_request(CMD_LOAD, 0);
		queue_request(CMD_BUILD);
		queue_request(CMD_SAMPLE, 0, 32'h0);
		queue_request(CMD_LOAD, 32'hffff_ffff);
		queue_request(CMD_LOAD, 32'd1);
		queue_request(CMD_LOAD, 32'd12345);
		queue_request(CMD_BUILD);
		queue_request(CMD_SAMPLE, 0, 32'h0);
		queue_request(CMD_SAMPLE, 0, 32'hffff_ffff);
		queue_request(CMD_SAMPLE, 0, 32'h8000_0000);
		queue_request(CMD_SAMPLE, 0, $urandom);
		queue_request(CMD_SAMPLE, 0, $urandom);
		queue_request(CMD_LOAD, 32'd7);
		queue_request(CMD_SAMPLE, 0, $urandom);
		queue_request(CMD_BUILD);
		queue_request(CMD_SAMPLE, 0, $urandom);
		queue_request(CMD_CLEAR);
		queue_request(CMD_SAMPLE, 0, $urandom);
		queue_request(CMD_BUILD, 0, 0, 1);

		// random
		count = 22;
		while (count < 1200) begin
			kind = $urandom_range(0, 19);
			if (kind == 0) begin
				queue_request(cmd_t'($urandom_range(0, 3)), pick_word(), pick_word());
				count++;
			end else if (kind == 1) begin
				k = $urandom_range(1, 4);
				queue_request(CMD_CLEAR);
				for (i = 0; i < k; i++)
					queue_request(CMD_LOAD, 0);
				queue_request(CMD_BUILD);
				queue_request(CMD_SAMPLE, 0, $urandom);
				count += k + 3;
			end else begin
				k = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
				queue_request(CMD_CLEAR, 0, 0, kind == 2);
				for (i = 0; i < k; i++)
					queue_request(CMD_LOAD, pick_word());
				queue_request(CMD_BUILD);
				if ($urandom_range(0, 4) == 0)
					queue_request(CMD_LOAD, pick_word());
				for (i = $urandom_range(5, 25); i > 0; i--)
					queue_request(CMD_SAMPLE, pick_word(), pick_word());
				count += k + 20;
			end
			if (count > 100 && !full_done) begin
				queue_request(CMD_CLEAR);
				for (i = 0; i < N_MAX + 2; i++)
					queue_request(CMD_LOAD, $urandom);
				queue_request(CMD_BUILD);
				for (i = 0; i < 20; i++)
					queue_request(CMD_SAMPLE, 0, pick_word());
				full_done = 1;
				count += N_MAX + 24;
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_requests.size() > 0 || in_ch.valid)
			@(posedge clk);
		while (expected_answers.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_answers.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("TB_ERROR");
		$finish;
	end
endmodule
